/* hw/rtl/lbrd_pkg.sv */
// shared constants and types for the bounded random draw unit
package lbrd_pkg;

    localparam int LCG_BITS     = 48;
    localparam int SAMPLE_SHIFT = 17;
    localparam int SAMPLE_BITS  = 31;
    localparam int PROD_SHIFT   = 31;
    localparam int WORD_BITS    = 32;
    localparam int CHUNK_BITS   = 16;
    localparam int NUM_CHUNKS   = 3;
    localparam int CHUNK_CNT_W  = $clog2(NUM_CHUNKS);
    localparam int DIV_CNT_W    = $clog2(SAMPLE_BITS);

    localparam logic [LCG_BITS-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
    localparam logic [LCG_BITS-1:0] LCG_ADD  = 48'h0000_0000_000B;

    typedef logic [LCG_BITS-1:0]    lcg_state_t;
    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // status of an iterative unit seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

/* hw/rtl/lcg_bounded_random_draw_unit.sv */
// Bounded uniform draw: one transaction carries a bound and a 32-bit seed and returns one value
// below the bound. A bound of one or less answers zero. Otherwise each generator step runs in the
// 48x16 multiply-accumulate unit; a power-of-two bound adds the scaling product, any other bound
// adds a pass through the one-bit-per-cycle remainder unit, and every rejected sample repeats the
// step and the remainder. The request side is ready only while the sequencer is idle; a finished
// draw waits in an output register, so the next request can start before it is taken.
module lcg_bounded_random_draw_unit
    import lbrd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic signed [WORD_BITS-1:0] bound,
    input  logic signed [WORD_BITS-1:0] seed_value,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [SAMPLE_BITS-1:0] draw
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LCG   = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_POW   = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [WORD_BITS-1:0] bound_reg;
    logic [WORD_BITS-1:0] bound_next;
    logic                 pow_reg;
    logic                 pow_next;
    lcg_state_t           st_reg;
    lcg_state_t           st_next;
    sample_t              sample_reg;
    sample_t              sample_next;
    sample_t              res_reg;
    sample_t              res_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    sample_t              draw_reg;
    sample_t              draw_next;

    logic                 lcg_start;
    lcg_state_t           lcg_in;
    lcg_state_t           lcg_out;
    unit_stat_t           lcg_stat;
    logic                 mod_start;
    sample_t              mod_rem;
    unit_stat_t           mod_stat;

    logic [WORD_BITS-1:0] bound_u;
    logic                 bound_trivial;
    logic                 bound_pow2;
    lcg_state_t           seed_ext;
    logic [2*SAMPLE_BITS-1:0] scaled;
    logic [WORD_BITS-1:0] reject_sum;
    logic                 load_out;

    assign bound_u       = bound;
    assign bound_trivial = bound_u[WORD_BITS-1] || (bound_u <= WORD_BITS'(1));
    assign bound_pow2    = ((bound_u & (bound_u - WORD_BITS'(1))) == '0);
    assign seed_ext      = {{(LCG_BITS-WORD_BITS){seed_value[WORD_BITS-1]}}, seed_value};

    // power-of-two bound: (bound * sample) >> 31
    assign scaled = {{SAMPLE_BITS{1'b0}}, bound_reg[SAMPLE_BITS-1:0]}
                  * {{SAMPLE_BITS{1'b0}}, sample_reg};

    // reject test: sample - rem + (bound - 1) overflows into the sign bit
    assign reject_sum = {1'b0, sample_reg} - {1'b0, mod_rem} + (bound_reg - WORD_BITS'(1));

    assign lcg_in    = (state_reg == ST_IDLE) ? seed_ext : st_reg;
    assign load_out  = (state_reg == ST_WRITE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next  = state_reg;
        bound_next  = bound_reg;
        pow_next    = pow_reg;
        st_next     = st_reg;
        sample_next = sample_reg;
        res_next    = res_reg;
        lcg_start   = 1'b0;
        mod_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    bound_next = bound_u;
                    pow_next   = bound_pow2;
                    if (bound_trivial)
                    begin
                        res_next   = '0;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        lcg_start  = 1'b1;
                        state_next = ST_LCG;
                    end
                end
            end
            ST_LCG:
            begin
                if (lcg_stat.done)
                begin
                    st_next     = lcg_out;
                    sample_next = lcg_out[LCG_BITS-1:SAMPLE_SHIFT];
                    if (pow_reg)
                        state_next = ST_POW;
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_stat.done)
                begin
                    if (reject_sum[WORD_BITS-1])
                    begin
                        lcg_start  = 1'b1;
                        state_next = ST_LCG;
                    end
                    else
                    begin
                        res_next   = mod_rem;
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_POW:
            begin
                res_next   = scaled[PROD_SHIFT +: SAMPLE_BITS];
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        draw_next      = draw_reg;
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
            draw_next      = res_reg;
        end
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg  <= bound_next;
        pow_reg    <= pow_next;
        st_reg     <= st_next;
        sample_reg <= sample_next;
        res_reg    <= res_next;
        draw_reg   <= draw_next;
    end

    lbrd_lcg u_lcg (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (lcg_start),
        .state_in  (lcg_in),
        .state_out (lcg_out),
        .stat      (lcg_stat)
    );

    lbrd_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (lcg_out[LCG_BITS-1:SAMPLE_SHIFT]),
        .divisor  (bound_reg[SAMPLE_BITS-1:0]),
        .rem      (mod_rem),
        .stat     (mod_stat)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign draw      = draw_reg;

    // the two units never run at the same time
    assert property (@(posedge clk) disable iff (!rst_n)
        !(lcg_stat.busy && mod_stat.busy))
        else $error("generator and remainder unit busy together");

    assert property (@(posedge clk) disable iff (!rst_n)
        lcg_stat.done |-> (state_reg == ST_LCG))
        else $error("generator step finished outside its wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        mod_stat.done |-> (state_reg == ST_MOD))
        else $error("remainder finished outside its wait state");

    // a nontrivial bound always yields a draw below it
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !bound_reg[WORD_BITS-1] && (bound_reg > WORD_BITS'(1)))
        |-> ({1'b0, res_reg} < bound_reg))
        else $error("draw not below bound");

endmodule

/* hw/rtl/lbrd_lcg.sv */
// iterative generator step: state * multiplier + increment, one 16-bit chunk per cycle
module lbrd_lcg
    import lbrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  lcg_state_t state_in,
    output lcg_state_t state_out,
    output unit_stat_t stat
);

    logic [CHUNK_CNT_W-1:0] cnt_reg;
    logic [CHUNK_CNT_W-1:0] cnt_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    lcg_state_t             acc_reg;
    lcg_state_t             acc_next;
    lcg_state_t             mul_reg;
    lcg_state_t             mul_next;
    logic [CHUNK_BITS-1:0]  chunk;
    logic [LCG_BITS+CHUNK_BITS-1:0] prod;
    lcg_state_t             shifted;

    assign chunk = LCG_MULT[cnt_reg*CHUNK_BITS +: CHUNK_BITS];
    assign prod  = {{CHUNK_BITS{1'b0}}, mul_reg} * {{LCG_BITS{1'b0}}, chunk};

    // partial product weighted by its chunk position, wrapped to the state width
    always_comb
    begin
        case (cnt_reg)
            2'd0:    shifted = prod[LCG_BITS-1:0];
            2'd1:    shifted = {prod[LCG_BITS-CHUNK_BITS-1:0], {CHUNK_BITS{1'b0}}};
            2'd2:    shifted = {prod[LCG_BITS-2*CHUNK_BITS-1:0], {2*CHUNK_BITS{1'b0}}};
            default: shifted = '0;
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        mul_next  = mul_reg;
        if (start)
        begin
            // increment preloaded into the accumulator
            acc_next  = LCG_ADD;
            mul_next  = state_in;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + shifted;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CHUNK_CNT_W'(NUM_CHUNKS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mul_reg <= mul_next;
    end

    assign state_out = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* hw/rtl/lbrd_mod.sv */
// restoring remainder unit, one dividend bit per cycle
module lbrd_mod
    import lbrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  sample_t    dividend,
    input  sample_t    divisor,
    output sample_t    rem,
    output unit_stat_t stat
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    sample_t              dvd_reg;
    sample_t              dvd_next;
    sample_t              dsr_reg;
    sample_t              dsr_next;
    sample_t              rem_reg;
    sample_t              rem_next;
    logic [SAMPLE_BITS:0]   shifted;
    logic [SAMPLE_BITS+1:0] diff;

    assign shifted = {rem_reg, dvd_reg[SAMPLE_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the difference unless it borrowed
            if (!diff[SAMPLE_BITS+1])
                rem_next = diff[SAMPLE_BITS-1:0];
            else
                rem_next = shifted[SAMPLE_BITS-1:0];
            dvd_next = {dvd_reg[SAMPLE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(SAMPLE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rem       = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
